[design/tsdp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the two-server move-cost block.
package tsdp_pkg;

	localparam int unsigned POS_W = 11;
	localparam int unsigned RES_W = 32;
	localparam logic [POS_W-1:0] POSITIONS_RESET = 11'd1024;

	typedef struct packed {
		logic [POS_W-1:0] source_pos;
		logic [POS_W-1:0] dest_pos;
		logic             first_of_test;
	} query_t;

	typedef struct packed {
		logic [RES_W-1:0] min_total_cost;
		logic             range_error;
	} result_t;

	// What a query does to the table
	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_INIT   = 2'd2,
		MODE_UPDATE = 2'd3
	} mode_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic  issue_done;
		logic  drained;
		mode_t mode;
	} sts_t;

endpackage

[design/tsdp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module tsdp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1025
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/tsdp_dp.sv]
`timescale 1ns / 1ps
// Datapath: cost table, walk pipeline, min tracking and result register.
module tsdp_dp #(
	parameter int unsigned MAX_POSITIONS = 1024,
	parameter int unsigned COST_BITS     = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsdp_pkg::cmd_t             cmd,
	output tsdp_pkg::sts_t             sts,
	input  tsdp_pkg::query_t           query,
	input  logic                       cfg_we,
	input  logic [tsdp_pkg::POS_W-1:0] cfg_wdata,
	output tsdp_pkg::result_t          result
);

	localparam int unsigned DEPTH = MAX_POSITIONS + 1;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam int unsigned DW    = (IDX_W > tsdp_pkg::POS_W) ? IDX_W : tsdp_pkg::POS_W;
	localparam int unsigned OFF_W = DW + 1;
	localparam int unsigned SUM_W = ((COST_BITS > OFF_W) ? COST_BITS : OFF_W) + 1;
	localparam int unsigned MW    = (COST_BITS > tsdp_pkg::RES_W) ? COST_BITS : tsdp_pkg::RES_W;
	localparam logic [COST_BITS-1:0] ONES   = {COST_BITS{1'b1}};
	localparam logic [DW-1:0]        MAXPOS = DW'(MAX_POSITIONS);
	localparam logic [CNT_W-1:0]     LAST   = CNT_W'(DEPTH);

	localparam int unsigned PW = tsdp_pkg::POS_W;

	function automatic logic [COST_BITS-1:0] sat_add(
		input logic [COST_BITS-1:0] x,
		input logic [OFF_W-1:0]     y
	);
		logic [SUM_W-1:0] s;
		s = SUM_W'(x) + SUM_W'(y);
		return (s > SUM_W'(ONES)) ? ONES : s[COST_BITS-1:0];
	endfunction

	function automatic logic [PW-1:0] pdist(input logic [PW-1:0] x, input logic [PW-1:0] y);
		return (x > y) ? (x - y) : (y - x);
	endfunction

	// configuration and sequence state
	logic [PW-1:0]  cfg_q;
	logic [PW-1:0]  last_dest_q;
	logic           started_q;

	// item registers
	logic [PW-1:0]  a_q;
	logic [PW-1:0]  d_q;
	logic [PW-1:0]  hop_q;
	logic [PW:0]    stay_q;
	logic           err_q;
	tsdp_pkg::mode_t mode_q;

	// walk
	logic [CNT_W-1:0]     rd_cnt_q;
	logic                 v_s1, v_s2;
	logic [IDX_W-1:0]     idx_s1, idx_s2;
	logic [OFF_W-1:0]     off_s1;
	logic [COST_BITS-1:0] wval_s2, cand_s2;
	logic [COST_BITS-1:0] min_acc_q, best_q, newd_q;

	logic [tsdp_pkg::RES_W-1:0] res_cost_q;
	logic                       res_err_q;

	// load decode
	logic [DW-1:0]   lim;
	logic [DW-1:0]   cfg_ext;
	logic            in_err;
	tsdp_pkg::mode_t mode_d;
	logic [PW-1:0]   hop_d;
	logic [PW:0]     stay_d;

	always_comb begin
		cfg_ext = DW'(cfg_q);
		lim     = (cfg_ext > MAXPOS) ? MAXPOS : cfg_ext;
		in_err  = (query.source_pos == '0) || (DW'(query.source_pos) > lim) ||
		          (query.dest_pos == '0) || (DW'(query.dest_pos) > lim);
		hop_d   = pdist(query.source_pos, query.dest_pos);
		stay_d  = (PW+1)'(hop_d) + (PW+1)'(pdist(query.source_pos, last_dest_q));
		if (in_err) begin
			mode_d = query.first_of_test ? tsdp_pkg::MODE_CLEAR : tsdp_pkg::MODE_NONE;
		end else if (query.first_of_test || !started_q) begin
			mode_d = tsdp_pkg::MODE_INIT;
		end else begin
			mode_d = tsdp_pkg::MODE_UPDATE;
		end
	end

	// read issue and per-entry offer
	logic [IDX_W-1:0] rd_idx;
	logic [DW-1:0]    i_ext, a_ext, dia;
	logic [OFF_W-1:0] off_d;

	always_comb begin
		rd_idx = rd_cnt_q[IDX_W-1:0];
		i_ext  = DW'(rd_idx);
		a_ext  = DW'(a_q);
		dia    = (i_ext > a_ext) ? (i_ext - a_ext) : (a_ext - i_ext);
		off_d  = (rd_idx == '0) ? OFF_W'(hop_q) : (OFF_W'(hop_q) + OFF_W'(dia));
	end

	logic [COST_BITS-1:0] rdata;
	logic [COST_BITS-1:0] wval_d;

	always_comb begin
		case (mode_q)
			tsdp_pkg::MODE_UPDATE: wval_d = sat_add(rdata, OFF_W'(stay_q));
			tsdp_pkg::MODE_INIT:   wval_d = (idx_s1 == '0) ? sat_add('0, OFF_W'(hop_q)) : ONES;
			default:               wval_d = ONES;
		endcase
	end

	// RAM write: walk write-back or final fix of the last-destination entry
	logic [DW-1:0]        d_ext;
	logic [IDX_W-1:0]     d_idx;
	logic                 fix_wr;
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [COST_BITS-1:0] ram_wdata;

	always_comb begin
		d_ext     = DW'(d_q);
		d_idx     = d_ext[IDX_W-1:0];
		fix_wr    = cmd.fix && (best_q < newd_q);
		ram_we    = v_s2 || fix_wr;
		ram_waddr = cmd.fix ? d_idx : idx_s2;
		ram_wdata = cmd.fix ? best_q : wval_s2;
	end

	tsdp_ram #(
		.WIDTH(COST_BITS),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.issue),
		.raddr(rd_idx),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= tsdp_pkg::POSITIONS_RESET;
			last_dest_q <= '0;
			started_q   <= 1'b0;
			mode_q      <= tsdp_pkg::MODE_CLEAR;
			rd_cnt_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			min_acc_q   <= ONES;
			best_q      <= ONES;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.load) begin
				mode_q <= mode_d;
				if (!in_err) begin
					last_dest_q <= query.dest_pos;
					started_q   <= 1'b1;
				end else if (query.first_of_test) begin
					started_q <= 1'b0;
				end
				if (mode_d != tsdp_pkg::MODE_NONE) begin
					rd_cnt_q  <= '0;
					min_acc_q <= ONES;
					best_q    <= ONES;
				end
			end
			if (cmd.issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (wval_s2 < min_acc_q) begin
					min_acc_q <= wval_s2;
				end
				if (mode_q == tsdp_pkg::MODE_UPDATE && cand_s2 < best_q) begin
					best_q <= cand_s2;
				end
			end
			if (cmd.fix && best_q < min_acc_q) begin
				min_acc_q <= best_q;
			end
		end
	end

	logic [MW-1:0] min_ext;
	assign min_ext = MW'(min_acc_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= query.source_pos;
			d_q    <= last_dest_q;
			hop_q  <= hop_d;
			stay_q <= stay_d;
			err_q  <= in_err;
		end
		idx_s1  <= rd_idx;
		off_s1  <= off_d;
		idx_s2  <= idx_s1;
		wval_s2 <= wval_d;
		cand_s2 <= sat_add(rdata, off_s1);
		if (v_s2 && idx_s2 == d_idx) begin
			newd_q <= wval_s2;
		end
		if (cmd.out_load) begin
			res_cost_q <= min_ext[tsdp_pkg::RES_W-1:0];
			res_err_q  <= err_q;
		end
	end

	assign sts.issue_done = (rd_cnt_q == LAST);
	assign sts.drained    = !v_s1 && !v_s2;
	assign sts.mode       = mode_q;

	assign result.min_total_cost = res_cost_q;
	assign result.range_error    = res_err_q;

endmodule

[design/tsdp_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine: table clear, walk sequencing and result handshake.
module tsdp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           query_valid,
	output logic           query_ready,
	output logic           result_valid,
	input  logic           result_ready,
	output tsdp_pkg::cmd_t cmd,
	input  tsdp_pkg::sts_t sts
);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_WALK = 5'b00100,
		ST_FIX  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   walk_end;

	always_comb begin
		walk_end     = sts.issue_done && sts.drained;
		query_ready  = (state_q == ST_IDLE);
		cmd.load     = 1'b0;
		cmd.issue    = 1'b0;
		cmd.fix      = 1'b0;
		cmd.out_load = 1'b0;
		state_d      = state_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.issue = !sts.issue_done;
				if (walk_end) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (query_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.mode == tsdp_pkg::MODE_NONE) begin
					state_d = ST_DONE;
				end else begin
					cmd.issue = !sts.issue_done;
					if (walk_end) begin
						state_d = (sts.mode == tsdp_pkg::MODE_UPDATE) ? ST_FIX : ST_DONE;
					end
				end
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

endmodule

[design/two_server_move_cost_dp_top.sv]
`timescale 1ns / 1ps
// Two-server move-cost block: query channel in, result channel out.
//
// Each query item carries a source and destination position plus a
// first_of_test flag; each query returns exactly one result item with the
// least total travel cost so far and a range_error flag.
// Both channels are valid/ready; an item moves when valid and ready are high.
// cfg_we/cfg_wdata write positions_in_use at any edge with cfg_we high.
// A query walks the whole cost table, one entry per cycle through the
// single read port of the table RAM. A query with an out-of-range
// position and no first_of_test flag skips the walk. Items are processed
// one at a time. After reset the table is cleared to all ones, one entry
// per cycle; query_ready stays low until that finishes.
// The result sits in an output register: the next query is accepted while
// it waits, and that query's walk runs, but its result holds until the
// receiver takes the one before it.
module two_server_move_cost_dp_top #(
	parameter int unsigned MAX_POSITIONS = 1024,
	parameter int unsigned COST_BITS     = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       query_valid,
	output logic                       query_ready,
	input  tsdp_pkg::query_t           query,
	output logic                       result_valid,
	input  logic                       result_ready,
	output tsdp_pkg::result_t          result,
	input  logic                       cfg_we,
	input  logic [tsdp_pkg::POS_W-1:0] cfg_wdata
);

	tsdp_pkg::cmd_t cmd;
	tsdp_pkg::sts_t sts;

	tsdp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.query_valid (query_valid),
		.query_ready (query_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	tsdp_dp #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.COST_BITS    (COST_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.query    (query),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.result   (result)
	);

endmodule

[dv/two_server_move_cost_dp_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-server move-cost block, with its own cost-table predictor.
module two_server_move_cost_dp_top_tb;

	localparam int unsigned MAX_POS     = 1024;
	localparam int unsigned COST_W      = 32;
	localparam int unsigned POS_W       = tsdp_pkg::POS_W;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned TAIL_ITEMS  = 40;

	class move_cost_checker;
		logic [COST_W-1:0]   cost_tbl [MAX_POS+1];
		logic [POS_W-1:0]    last_dest;
		bit                  started;
		logic [POS_W-1:0]    positions;
		tsdp_pkg::result_t   costs_due[$];
		int                  errors;

		function new();
			clear_table();
			last_dest = '0;
			started   = 1'b0;
			positions = tsdp_pkg::POSITIONS_RESET;
			errors    = 0;
		endfunction

		function void set_positions(logic [POS_W-1:0] v);
			positions = v;
		endfunction

		function void clear_table();
			foreach (cost_tbl[i]) cost_tbl[i] = '1;
		endfunction

		function logic [COST_W-1:0] sat_add(logic [COST_W-1:0] x, logic [COST_W-1:0] y);
			logic [COST_W:0] s;
			if (x == '1 || y == '1) return '1;
			s = {1'b0, x} + {1'b0, y};
			return s[COST_W] ? '1 : s[COST_W-1:0];
		endfunction

		function logic [COST_W-1:0] span(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
			logic [COST_W-1:0] wx;
			logic [COST_W-1:0] wy;
			wx = x;
			wy = y;
			return (wx > wy) ? wx - wy : wy - wx;
		endfunction

		function logic [COST_W-1:0] least_cost();
			logic [COST_W-1:0] m;
			m = '1;
			foreach (cost_tbl[i]) if (cost_tbl[i] < m) m = cost_tbl[i];
			return m;
		endfunction

		function tsdp_pkg::result_t walk_table(tsdp_pkg::query_t q);
			tsdp_pkg::result_t r;
			int unsigned       lim;
			logic [COST_W-1:0] hop;
			logic [COST_W-1:0] stay;
			logic [COST_W-1:0] best;
			logic [COST_W-1:0] offer;
			lim = (positions > MAX_POS) ? MAX_POS : positions;
			if (q.first_of_test) begin
				clear_table();
				started = 1'b0;
			end
			if (q.source_pos < 1 || q.source_pos > lim || q.dest_pos < 1 || q.dest_pos > lim) begin
				r.min_total_cost = least_cost();
				r.range_error    = 1'b1;
				return r;
			end
			if (!started) begin
				clear_table();
				cost_tbl[0] = span(q.source_pos, q.dest_pos);
				started     = 1'b1;
			end else begin
				hop  = span(q.dest_pos, q.source_pos);
				stay = sat_add(hop, span(q.source_pos, last_dest));
				best = '1;
				// idle mover takes the query; slot 0 is unplaced and reaches the source free
				for (int i = 0; i <= MAX_POS; i++) begin
					offer = sat_add(cost_tbl[i],
						(i == 0) ? hop : sat_add(hop, span(POS_W'(i), q.source_pos)));
					if (offer < best) best = offer;
				end
				for (int i = 0; i <= MAX_POS; i++) cost_tbl[i] = sat_add(cost_tbl[i], stay);
				if (best < cost_tbl[last_dest]) cost_tbl[last_dest] = best;
			end
			last_dest        = q.dest_pos;
			r.min_total_cost = least_cost();
			r.range_error    = 1'b0;
			return r;
		endfunction

		function void note_query(tsdp_pkg::query_t q);
			costs_due.push_back(walk_table(q));
		endfunction

		function void check_result(tsdp_pkg::result_t r);
			tsdp_pkg::result_t exp;
			if (costs_due.size() == 0) begin
				$error("result item with nothing expected: min_total_cost %0d range_error %0b",
					r.min_total_cost, r.range_error);
				errors++;
				return;
			end
			exp = costs_due.pop_front();
			if (r.min_total_cost !== exp.min_total_cost) begin
				$error("min_total_cost: expected %0d, actual %0d",
					exp.min_total_cost, r.min_total_cost);
				errors++;
			end
			if (r.range_error !== exp.range_error) begin
				$error("range_error: expected %0b, actual %0b", exp.range_error, r.range_error);
				errors++;
			end
		endfunction

		function int pending();
			return costs_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              query_valid;
	logic              query_ready;
	tsdp_pkg::query_t  query;
	logic              result_valid;
	logic              result_ready;
	tsdp_pkg::result_t result;
	logic              cfg_we;
	logic [POS_W-1:0]  cfg_wdata;

	move_cost_checker sb;
	bit               steady = 1'b0;
	int unsigned      cfg_positions = tsdp_pkg::POSITIONS_RESET;
	int unsigned      cycle_count = 0;

	two_server_move_cost_dp_top #(
		.MAX_POSITIONS(MAX_POS),
		.COST_BITS(COST_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_ready(query_ready),
		.query(query),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (query_valid && query_ready) sb.note_query(query);
			if (result_valid && result_ready) sb.check_result(result);
		end
	end

	// receiver back-pressure
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 19) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	function automatic tsdp_pkg::query_t mk_query(int unsigned src, int unsigned dst, bit first);
		tsdp_pkg::query_t q;
		q.source_pos    = POS_W'(src);
		q.dest_pos      = POS_W'(dst);
		q.first_of_test = first;
		return q;
	endfunction

	function automatic int unsigned pick_pos(int unsigned lim);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 1;
		if (r == 1) return lim;
		return $urandom_range(1, lim);
	endfunction

	function automatic int unsigned off_pos(int unsigned lim);
		if ($urandom_range(0, 1) == 0) return 0;
		return $urandom_range(lim + 1, 2047);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_query(tsdp_pkg::query_t q);
		if (!steady && $urandom_range(0, 2) == 0) begin
			query_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		query       <= q;
		query_valid <= 1'b1;
		@(posedge clk);
		while (!query_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		query_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic program_positions(int unsigned v);
		cfg_wdata     <= POS_W'(v);
		cfg_we        <= 1'b1;
		sb.set_positions(POS_W'(v));
		cfg_positions = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly query sequences inside the range, some noise and broken items
	task automatic run_phase(int n_items, bit quiet_tail);
		int unsigned      lim;
		int               left;
		int               seq_len;
		int unsigned      r;
		tsdp_pkg::query_t q;
		lim  = (cfg_positions > MAX_POS) ? MAX_POS : cfg_positions;
		left = n_items;
		while (left > 0) begin
			seq_len = $urandom_range(1, 12);
			for (int k = 0; k < seq_len && left > 0; k++) begin
				if (quiet_tail && left <= TAIL_ITEMS) steady = 1'b1;
				r = $urandom_range(0, 99);
				q.first_of_test = (k == 0) ? ($urandom_range(0, 4) != 0)
					: ($urandom_range(0, 29) == 0);
				if (lim == 0 || r < 8) begin
					q.source_pos = POS_W'($urandom_range(0, 2047));
					q.dest_pos   = POS_W'($urandom_range(0, 2047));
				end else if (r < 12) begin
					q.source_pos = POS_W'(pick_pos(lim));
					q.dest_pos   = POS_W'(pick_pos(lim));
					if ($urandom_range(0, 1) == 0) q.source_pos = POS_W'(off_pos(lim));
					else q.dest_pos = POS_W'(off_pos(lim));
				end else begin
					q.source_pos = POS_W'(pick_pos(lim));
					q.dest_pos   = POS_W'(pick_pos(lim));
				end
				send_query(q);
				left--;
			end
		end
	endtask

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		query_valid = 1'b0;
		query       = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at the reset setting
		send_query(mk_query(5, 9, 0));
		send_query(mk_query(1, 1024, 0));
		send_query(mk_query(1024, 1, 0));
		send_query(mk_query(1024, 1024, 0));
		send_query(mk_query(1, 1, 0));
		send_query(mk_query(0, 5, 0));
		send_query(mk_query(5, 0, 0));
		send_query(mk_query(1025, 3, 0));
		send_query(mk_query(3, 2047, 0));
		send_query(mk_query(512, 700, 1));
		send_query(mk_query(700, 512, 0));
		send_query(mk_query(2047, 2047, 1));
		send_query(mk_query(0, 0, 0));
		send_query(mk_query(1, 2, 0));
		send_query(mk_query(2, 1, 0));
		send_query(mk_query(1024, 1023, 0));
		send_query(mk_query(341, 682, 0));
		send_query(mk_query(682, 341, 1));
		send_query(mk_query(1023, 1, 0));
		send_query(mk_query(1365, 1, 0));
		run_phase(120, 0);

		drain();
		program_positions(2047);
		run_phase(60, 0);
		drain();
		program_positions(0);
		run_phase(30, 0);
		drain();
		program_positions(1);
		run_phase(40, 0);
		drain();
		program_positions($urandom_range(2, 16));
		run_phase(80, 0);
		drain();
		program_positions($urandom_range(17, 1023));
		run_phase(100, 0);
		drain();
		program_positions(1024);
		run_phase(110, 1);

		drain();
		repeat (1100) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
